### design/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is suspended while reset is asserted.
`define JRB_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
    else $error("jitter buffer assertion failed");

// Clocked check that also holds during reset.
`define JRB_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
    else $error("jitter buffer reset assertion failed");

`endif

### design/jrb_pkg.sv
// Package with types, constants and codes of the jitter reorder buffer.
package jrb_pkg;

    localparam int DEPTH       = 32;
    localparam int CW          = $clog2(DEPTH + 1);
    localparam int MAX_RESULTS = 32;
    localparam int NW          = $clog2(MAX_RESULTS);

    // Function codes of an input item.
    localparam logic [2:0] FN_INSERT = 3'd0;
    localparam logic [2:0] FN_DEQ    = 3'd1;
    localparam logic [2:0] FN_QUERY  = 3'd2;
    localparam logic [2:0] FN_FLUSH  = 3'd3;
    localparam logic [2:0] FN_PEEK   = 3'd4;

    // Status codes of a result.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_DTMF    = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_DUP     = 3'd3;
    localparam logic [2:0] ST_SEQERR  = 3'd4;
    localparam logic [2:0] ST_MISSING = 3'd5;
    localparam logic [2:0] ST_FULL    = 3'd6;
    localparam logic [2:0] ST_DONE    = 3'd7;

    // Cell operations.
    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_SHIFT  = 2'd2;
    localparam logic [1:0] OP_ROTATE = 2'd3;

    typedef struct packed {
        logic [15:0] seq;
        logic [10:0] len;
        logic        mark;
        logic [7:0]  tag;
    } t_entry;

    typedef struct packed {
        logic [1:0] op;
        logic       occ;
        logic       at_tail;
        logic       is_last;
    } t_cell_ctl;

endpackage

### design/jrb_cell.sv
// One slot of the sorted descriptor chain.
module jrb_cell
    import jrb_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_new,
    input  t_entry    i_left,
    input  logic      i_left_ge,
    input  t_entry    i_right,
    input  t_entry    i_head,
    output t_entry    o_entry,
    output logic      o_ge
);

    t_entry r_entry;
    t_entry n_entry;

    // The slot is occupied and its sequence is not below the new one.
    assign o_ge    = i_ctl.occ && !(r_entry.seq < i_new.seq);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_ctl.op)
            OP_INSERT: begin
                if (o_ge || i_ctl.at_tail) begin
                    n_entry = i_left_ge ? i_left : i_new;
                end
            end
            OP_SHIFT: begin
                n_entry = i_right;
            end
            OP_ROTATE: begin
                if (i_ctl.is_last) begin
                    n_entry = i_head;
                end else if (i_ctl.occ) begin
                    n_entry = i_right;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

### design/rtp_jitter_reorder_buffer.sv
// Top level of the RTP jitter reorder buffer: control, result register and cell chain.
//
//  channel | direction | handshake                 | payload
//  in      | input     | i_in_valid / o_in_stall   | func, seq_number, packet_length, marker,
//          |           |                           | is_dtmf, buffer_tag, payload_offset,
//          |           |                           | stop_at_marker
//  out     | output    | o_out_valid / i_out_stall | status, tag_out, seq_out, frame_bytes,
//          |           |                           | found, tag_valid, last
//  cfg     | input     | APB psel/penable/pwrite   | header_bytes, late_window
//
// An item is captured in the idle state and executed in the execute state, where insert,
// dequeue and peek finish; a flush removes its entries one by one, and a frame query
// goes on to the scan state, where the whole chain rotates once past its head cell.
// Reset clears the entry count, the state and the result valid flag; no clearing pass.
// A stalled result holds the block in place; the next item is still taken while a
// result waits.
module rtp_jitter_reorder_buffer
    import jrb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_func,
    input  logic [15:0]        i_seq_number,
    input  logic [10:0]        i_packet_length,
    input  logic               i_marker,
    input  logic               i_is_dtmf,
    input  logic [7:0]         i_buffer_tag,
    input  logic [7:0]         i_payload_offset,
    input  logic               i_stop_at_marker,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_status,
    output logic [7:0]         o_tag_out,
    output logic [15:0]        o_seq_out,
    output logic signed [16:0] o_frame_bytes,
    output logic               o_found,
    output logic               o_tag_valid,
    output logic               o_last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    // Configuration registers.
    logic [7:0]  r_header_bytes;
    logic [15:0] r_late_window;

    // Control state.
    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [NW-1:0] r_n, n_n;

    // Captured input item.
    logic [2:0]  r_func;
    logic [15:0] r_seq;
    logic [10:0] r_len;
    logic        r_mark;
    logic        r_dtmf;
    logic [7:0]  r_tag;
    logic [7:0]  r_poff;
    logic        r_stop;

    // Frame query walk.
    logic [CW-1:0]      r_idx, n_idx;
    logic [16:0]        r_want, n_want;
    logic signed [17:0] r_sum, n_sum;
    logic               r_done, n_done;
    logic               r_broke, n_broke;

    // Result register.
    logic               r_out_valid;
    logic [2:0]         r_status, n_status;
    logic [7:0]         r_tag_out, n_tag_out;
    logic [15:0]        r_seq_out, n_seq_out;
    logic signed [16:0] r_fb, n_fb;
    logic               r_found, n_found;
    logic               r_tv, n_tv;
    logic               r_last, n_last;
    logic               load;

    logic       in_xfer;
    logic       out_free;
    logic       cfg_wr;
    logic [1:0] op;

    t_entry new_entry;
    t_entry head;
    t_entry cell_q [DEPTH];
    logic   cell_ge [DEPTH];

    logic [16:0]        seq_ext;
    logic [16:0]        head_ext;
    logic signed [17:0] term;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    assign new_entry.seq  = r_seq;
    assign new_entry.len  = r_dtmf ? 11'd0 : r_len;
    assign new_entry.mark = r_mark;
    assign new_entry.tag  = r_tag;

    assign head     = cell_q[0];
    assign seq_ext  = {1'b0, r_seq};
    assign head_ext = {1'b0, head.seq};

    // Payload bytes of the head entry in a frame query; may be negative.
    assign term = $signed({7'd0, head.len}) - $signed({10'd0, r_header_bytes})
                - $signed({10'd0, r_poff});

    // The chain of cells: each slot takes from its left neighbor on insert and from
    // its right neighbor on removal; the last occupied slot takes the head on rotate.
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        t_cell_ctl ctl;
        t_entry    left_e;
        t_entry    right_e;
        logic      left_ge;

        assign ctl.op      = op;
        assign ctl.occ     = (CW'(gi) < r_count);
        assign ctl.at_tail = (CW'(gi) == r_count);
        assign ctl.is_last = ((CW + 1)'(gi + 1) == {1'b0, r_count});

        if (gi == 0) begin : g_first
            assign left_e  = '0;
            assign left_ge = 1'b0;
        end else begin : g_inner
            assign left_e  = cell_q[gi-1];
            assign left_ge = cell_ge[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_end
            assign right_e = '0;
        end else begin : g_mid
            assign right_e = cell_q[gi+1];
        end

        jrb_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (ctl),
            .i_new     (new_entry),
            .i_left    (left_e),
            .i_left_ge (left_ge),
            .i_right   (right_e),
            .i_head    (head),
            .o_entry   (cell_q[gi]),
            .o_ge      (cell_ge[gi])
        );
    end

    // Sequencer: one step of the current item per cycle unless a stalled result holds it.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_n       = r_n;
        n_idx     = r_idx;
        n_want    = r_want;
        n_sum     = r_sum;
        n_done    = r_done;
        n_broke   = r_broke;
        op        = OP_HOLD;
        load      = 1'b0;
        n_status  = ST_OK;
        n_tag_out = '0;
        n_seq_out = '0;
        n_fb      = '0;
        n_found   = 1'b0;
        n_tv      = 1'b0;
        n_last    = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_EXEC;
                    n_n     = '0;
                end
            end
            S_EXEC: begin
                case (r_func)
                    FN_INSERT: begin
                        if (out_free) begin
                            load    = 1'b1;
                            n_state = S_IDLE;
                            if (r_count == CW'(DEPTH)) begin
                                n_status  = ST_FULL;
                                n_tag_out = r_tag;
                                n_seq_out = r_seq;
                                n_tv      = 1'b1;
                            end else begin
                                op      = OP_INSERT;
                                n_count = r_count + 1'b1;
                            end
                        end
                    end
                    FN_DEQ: begin
                        if (out_free) begin
                            load    = 1'b1;
                            n_state = S_IDLE;
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else if (head.seq == r_seq) begin
                                op        = OP_SHIFT;
                                n_count   = r_count - 1'b1;
                                n_status  = (head.len == '0) ? ST_DTMF : ST_OK;
                                n_tag_out = head.tag;
                                n_seq_out = head.seq;
                                n_tv      = 1'b1;
                            end else if (r_seq != '0 && head_ext == seq_ext - 17'd1) begin
                                op        = OP_SHIFT;
                                n_count   = r_count - 1'b1;
                                n_status  = ST_DUP;
                                n_tag_out = head.tag;
                                n_seq_out = head.seq;
                                n_tv      = 1'b1;
                            end else if (head.seq < r_seq ||
                                         head_ext > seq_ext + {1'b0, r_late_window}) begin
                                n_status = ST_SEQERR;
                            end else begin
                                n_status = ST_MISSING;
                            end
                        end
                    end
                    FN_QUERY: begin
                        n_state = S_SCAN;
                        n_idx   = '0;
                        n_want  = seq_ext;
                        n_sum   = '0;
                        n_done  = 1'b0;
                        n_broke = 1'b0;
                    end
                    FN_FLUSH: begin
                        if (out_free) begin
                            load = 1'b1;
                            if (r_count == '0) begin
                                n_status = ST_DONE;
                                n_state  = S_IDLE;
                            end else begin
                                op        = OP_SHIFT;
                                n_count   = r_count - 1'b1;
                                n_n       = r_n + 1'b1;
                                n_tag_out = head.tag;
                                n_seq_out = head.seq;
                                n_tv      = 1'b1;
                                n_last    = (r_stop && head.mark) || (r_count == CW'(1)) ||
                                            (r_n == NW'(MAX_RESULTS - 1));
                                n_status  = n_last ? ST_DONE : ST_OK;
                                if (n_last) begin
                                    n_state = S_IDLE;
                                end
                            end
                        end
                    end
                    FN_PEEK: begin
                        if (out_free) begin
                            load    = 1'b1;
                            n_state = S_IDLE;
                            n_found = (r_count != '0) && (head.seq == r_seq);
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SCAN: begin
                if (r_idx != r_count) begin
                    // Rotate once per entry so the chain ends in its original order.
                    op    = OP_ROTATE;
                    n_idx = r_idx + 1'b1;
                    if (!r_done && !r_broke) begin
                        if (head_ext != r_want) begin
                            n_broke = 1'b1;
                        end else begin
                            n_want = r_want + 17'd1;
                            n_sum  = r_sum + term;
                            n_done = head.mark;
                        end
                    end
                end else if (out_free) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                    n_found = r_done;
                    if (!r_done) begin
                        n_fb = '0;
                    end else if (r_sum > 18'sd65535) begin
                        n_fb = 17'sd65535;
                    end else if (r_sum < -18'sd65536) begin
                        n_fb = -17'sd65536;
                    end else begin
                        n_fb = r_sum[16:0];
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_n     <= n_n;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_want  <= n_want;
        r_sum   <= n_sum;
        r_done  <= n_done;
        r_broke <= n_broke;
        if (in_xfer) begin
            r_func <= i_func;
            r_seq  <= i_seq_number;
            r_len  <= i_packet_length;
            r_mark <= i_marker;
            r_dtmf <= i_is_dtmf;
            r_tag  <= i_buffer_tag;
            r_poff <= i_payload_offset;
            r_stop <= i_stop_at_marker;
        end
        if (load) begin
            r_status  <= n_status;
            r_tag_out <= n_tag_out;
            r_seq_out <= n_seq_out;
            r_fb      <= n_fb;
            r_found   <= n_found;
            r_tv      <= n_tv;
            r_last    <= n_last;
        end
    end

    // Configuration port: the register index is address bit 2.
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = paddr[2] ? {16'd0, r_late_window} : {24'd0, r_header_bytes};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_bytes <= 8'd12;
            r_late_window  <= 16'd50;
        end else if (cfg_wr) begin
            if (paddr[2]) begin
                r_late_window <= pwdata[15:0];
            end else begin
                r_header_bytes <= pwdata[7:0];
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_tag_out     = r_tag_out;
    assign o_seq_out     = r_seq_out;
    assign o_frame_bytes = r_fb;
    assign o_found       = r_found;
    assign o_tag_valid   = r_tv;
    assign o_last        = r_last;

endmodule

### design/jrb_checker.sv
// Port-level checks of the jitter reorder buffer and their binding.
`include "assert_macros.svh"

module jrb_checker
    import jrb_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [2:0]         o_status,
    input logic signed [16:0] o_frame_bytes,
    input logic               o_found,
    input logic               o_tag_valid
);

    // Only results that remove or drop a buffer may hand a tag back.
    logic tag_status_ok;

    assign tag_status_ok = (o_status == ST_OK) || (o_status == ST_DTMF) ||
                           (o_status == ST_DUP) || (o_status == ST_FULL) ||
                           (o_status == ST_DONE);

    `JRB_ASSERT(a_hold_valid, o_out_valid && i_out_stall |=> o_out_valid)
    `JRB_ASSERT_RST(a_reset_empty, !i_rst_n |=> !o_out_valid)
    `JRB_ASSERT(a_found_ok, o_out_valid && o_found |-> o_status == ST_OK)
    `JRB_ASSERT(a_fb_found, o_out_valid && o_frame_bytes != '0 |-> o_found)
    `JRB_ASSERT(a_tag_status, o_out_valid && o_tag_valid |-> tag_status_ok)

endmodule

bind rtp_jitter_reorder_buffer jrb_checker u_jrb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_status      (o_status),
    .o_frame_bytes (o_frame_bytes),
    .o_found       (o_found),
    .o_tag_valid   (o_tag_valid)
);

### dv/tb_rtp_jitter_reorder_buffer.sv
// Self-checking testbench of the RTP jitter reorder buffer with a scoreboard class.
module tb_rtp_jitter_reorder_buffer;
    import jrb_pkg::*;

    localparam int HANG_LIMIT = 20000;

    typedef struct {
        logic [2:0]         status;
        logic [7:0]         tag;
        logic [15:0]        seq;
        logic signed [16:0] bytes;
        logic               found;
        logic               tag_valid;
        logic               last;
    } t_result;

    // The scoreboard keeps its own copy of the descriptor table and the
    // registers, and queues the results that each accepted transfer causes.
    class jitter_scoreboard;
        t_entry    table_q[$];
        int        hdr_bytes;
        int        window;
        t_result   pending[$];
        int        errors;
        int        checked;
        int        ins_cnt, deq_cnt, qry_cnt, flush_cnt, peek_cnt;

        function void init();
            table_q.delete();
            hdr_bytes = 12;
            window = 50;
            pending.delete();
        endfunction

        function void push(logic [2:0] st, logic [7:0] tg, logic [15:0] sq,
                           int fb, logic fnd, logic tv);
            t_result r;
            r.status = st; r.tag = tg; r.seq = sq; r.bytes = fb[16:0];
            r.found = fnd; r.tag_valid = tv; r.last = 1'b0;
            pending.push_back(r);
        endfunction

        // Works out the results of one accepted input transfer.
        function void note_item(logic [2:0] fn, logic [15:0] sq, logic [10:0] len,
                                logic mk, logic dt, logic [7:0] tg,
                                logic [7:0] poff, logic stp);
            t_entry e;
            int pos, want, sum, n, h;
            bit done, halt;
            n = 0;
            if (fn == FN_INSERT) begin
                ins_cnt++;
                if (table_q.size() >= DEPTH) begin
                    push(ST_FULL, tg, sq, 0, 0, 1);
                end else begin
                    pos = table_q.size();
                    if (pos > 0 && !(table_q[pos-1].seq < sq)) begin
                        pos = 0;
                        while (pos < table_q.size() && table_q[pos].seq < sq) pos++;
                    end
                    e.seq = sq; e.len = dt ? 11'd0 : len; e.mark = mk; e.tag = tg;
                    table_q.insert(pos, e);
                    push(ST_OK, 0, 0, 0, 0, 0);
                end
                n = 1;
            end else if (fn == FN_DEQ) begin
                deq_cnt++;
                if (table_q.size() == 0) begin
                    push(ST_EMPTY, 0, 0, 0, 0, 0);
                end else begin
                    e = table_q[0];
                    h = e.seq;
                    if (h == int'(sq)) begin
                        void'(table_q.pop_front());
                        push(e.len == 0 ? ST_DTMF : ST_OK, e.tag, e.seq, 0, 0, 1);
                    end else if (sq > 0 && h == int'(sq) - 1) begin
                        void'(table_q.pop_front());
                        push(ST_DUP, e.tag, e.seq, 0, 0, 1);
                    end else if (h < int'(sq) || h > int'(sq) + window) begin
                        push(ST_SEQERR, 0, 0, 0, 0, 0);
                    end else begin
                        push(ST_MISSING, 0, 0, 0, 0, 0);
                    end
                end
                n = 1;
            end else if (fn == FN_QUERY) begin
                qry_cnt++;
                want = sq; sum = 0; done = 0;
                for (int i = 0; i < table_q.size() && !done; i++) begin
                    if (int'(table_q[i].seq) != want) break;
                    want++;
                    sum += int'(table_q[i].len) - hdr_bytes - int'(poff);
                    if (table_q[i].mark) done = 1;
                end
                if (!done) sum = 0;
                if (sum > 65535) sum = 65535;
                if (sum < -65536) sum = -65536;
                push(ST_OK, 0, 0, sum, done, 0);
                n = 1;
            end else if (fn == FN_FLUSH) begin
                flush_cnt++;
                if (table_q.size() == 0) begin
                    push(ST_DONE, 0, 0, 0, 0, 0);
                    n = 1;
                end else begin
                    halt = 0;
                    while (table_q.size() > 0 && !halt && n < MAX_RESULTS) begin
                        e = table_q.pop_front();
                        if (stp && e.mark) halt = 1;
                        push(ST_OK, e.tag, e.seq, 0, 0, 1);
                        n++;
                    end
                    pending[pending.size()-1].status = ST_DONE;
                end
            end else if (fn == FN_PEEK) begin
                peek_cnt++;
                push(ST_OK, 0, 0, 0, table_q.size() > 0 && table_q[0].seq == sq, 0);
                n = 1;
            end
            if (n > 0) pending[pending.size()-1].last = 1'b1;
        endfunction

        // Compares one accepted result with the oldest expectation.
        function void check_result(t_result act);
            t_result x;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result status=%0d tag=%0d seq=%0d",
                         $time, act.status, act.tag, act.seq);
                errors++;
                return;
            end
            x = pending.pop_front();
            checked++;
            if (act.status !== x.status) report("status", x.status, act.status);
            if (act.tag !== x.tag) report("tag_out", x.tag, act.tag);
            if (act.seq !== x.seq) report("seq_out", x.seq, act.seq);
            if (act.bytes !== x.bytes) report("frame_bytes", x.bytes, act.bytes);
            if (act.found !== x.found) report("found", x.found, act.found);
            if (act.tag_valid !== x.tag_valid) report("tag_valid", x.tag_valid, act.tag_valid);
            if (act.last !== x.last) report("last", x.last, act.last);
        endfunction

        function void report(string fld, int exp_v, int act_v);
            $display("%0t: %s mismatch expected %0d actual %0d", $time, fld, exp_v, act_v);
            errors++;
        endfunction
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_in_valid = 0;
    logic               o_in_stall;
    logic [2:0]         i_func = 0;
    logic [15:0]        i_seq_number = 0;
    logic [10:0]        i_packet_length = 0;
    logic               i_marker = 0;
    logic               i_is_dtmf = 0;
    logic [7:0]         i_buffer_tag = 0;
    logic [7:0]         i_payload_offset = 0;
    logic               i_stop_at_marker = 0;
    logic               o_out_valid;
    logic               i_out_stall = 0;
    logic [2:0]         o_status;
    logic [7:0]         o_tag_out;
    logic [15:0]        o_seq_out;
    logic signed [16:0] o_frame_bytes;
    logic               o_found;
    logic               o_tag_valid;
    logic               o_last;
    logic               psel = 0;
    logic               penable = 0;
    logic               pwrite = 0;
    logic [2:0]         paddr = 0;
    logic [31:0]        pwdata = 0;
    logic [31:0]        prdata;
    logic               pready;

    rtp_jitter_reorder_buffer dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    jitter_scoreboard sb = new();
    int  idle_pct = 6;       // idling chance per cycle, in percent, on both sides
    int  quiet_cycles = 0;
    bit  timed_out = 0;
    int  seq_base = 1000;    // running sequence for well-formed streams

    // Result side: random stall, checks every accepted transfer at the rising edge.
    always @(posedge i_clk) begin
        t_result r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            r.status = o_status; r.tag = o_tag_out; r.seq = o_seq_out;
            r.bytes = o_frame_bytes; r.found = o_found; r.tag_valid = o_tag_valid;
            r.last = o_last;
            sb.check_result(r);
        end
    end

    always @(negedge i_clk)
        i_out_stall <= i_rst_n && ($urandom_range(99) < idle_pct);

    // Watchdog: counts cycles in which neither channel moves a transfer.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > HANG_LIMIT) begin
            timed_out = 1;
        end
    end

    // Sends one item and waits until the block accepts it. Valid stays high on
    // return so that a following item can go out back to back; whoever stops
    // sending drops it at that same falling edge.
    task automatic send(logic [2:0] fn, logic [15:0] sq, logic [10:0] len = 0,
                        logic mk = 0, logic dt = 0, logic [7:0] tg = 0,
                        logic [7:0] poff = 0, logic stp = 0);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_func <= fn; i_seq_number <= sq; i_packet_length <= len; i_marker <= mk;
        i_is_dtmf <= dt; i_buffer_tag <= tg; i_payload_offset <= poff;
        i_stop_at_marker <= stp; i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_item(fn, sq, len, mk, dt, tg, poff, stp);
        @(negedge i_clk);
    endtask

    // Register write in a setup and an access cycle, only while the block is idle.
    task automatic write_reg(int idx, logic [31:0] val);
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        psel <= 1; pwrite <= 1; paddr <= 3'(4 * idx); pwdata <= val; penable <= 0;
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (idx == 0) sb.hdr_bytes = val[7:0];
        else sb.window = val[15:0];
    endtask

    // A well-formed frame: a run of packets ending in a marker, sent shuffled.
    task automatic send_frame(int cnt);
        int  order[$];
        int  j, k;
        for (j = 0; j < cnt; j++) order.push_back(j);
        for (j = cnt - 1; j > 0; j--) begin
            k = $urandom_range(j);
            {order[j], order[k]} = {order[k], order[j]};
        end
        foreach (order[m])
            send(FN_INSERT, 16'(seq_base + order[m]), 11'($urandom_range(2047)),
                 order[m] == cnt - 1, $urandom_range(9) == 0, 8'($urandom),
                 8'($urandom), 0);
    endtask

    task automatic run_random(int items);
        int n, fr, j;
        n = 0;
        while (n < items) begin
            if (sb.table_q.size() > 24) begin
                send(FN_FLUSH, 0, 0, 0, 0, 0, 0, 1'($urandom_range(1)));
                n++;
            end else if ($urandom_range(9) < 7) begin
                fr = $urandom_range(1, 5);
                send_frame(fr);
                n += fr;
                send(FN_QUERY, 16'(seq_base), 0, 0, 0, 0, 8'($urandom), 0);
                send(FN_PEEK, 16'(seq_base + $urandom_range(1)));
                n += 2;
                for (j = 0; j < fr; j++) begin
                    case ($urandom_range(5))
                        0: send(FN_DEQ, 16'(seq_base + j + 1));
                        1: send(FN_DEQ, 16'(seq_base + j - $urandom_range(60)));
                        default: send(FN_DEQ, 16'(seq_base + j));
                    endcase
                    n++;
                end
                seq_base = (seq_base + fr + $urandom_range(3)) % 60000;
            end else begin
                send(3'($urandom_range(4)), 16'($urandom), 11'($urandom), 1'($urandom),
                     1'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
                n++;
            end
        end
    endtask

    initial begin
        sb.init();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty cases, extremes, DTMF, duplicate, order, full table.
        send(FN_DEQ, 16'd5);
        send(FN_FLUSH, 0);
        send(FN_PEEK, 16'd0);
        send(FN_INSERT, 16'hFFFF, 11'h7FF, 1, 0, 8'hFF);
        send(FN_INSERT, 16'd0, 11'd0, 0, 1, 8'h00);
        send(FN_INSERT, 16'd3, 11'd100, 0, 0, 8'h55);
        send(FN_INSERT, 16'd3, 11'd20, 1, 0, 8'hAA);
        send(FN_QUERY, 16'd0, 0, 0, 0, 0, 8'hFF);
        send(FN_PEEK, 16'd0);
        send(FN_DEQ, 16'd0);
        send(FN_DEQ, 16'd4);
        send(FN_DEQ, 16'd1);
        send(FN_DEQ, 16'd60);
        send(FN_FLUSH, 0, 0, 0, 0, 0, 0, 1);
        send(FN_FLUSH, 0);
        for (int i = 0; i < DEPTH + 2; i++)
            send(FN_INSERT, 16'(200 + i), 11'h7FF, 0, 0, 8'(i));
        send(FN_QUERY, 16'd200);
        send(FN_FLUSH, 0, 0, 0, 0, 0, 0, 1);

        // Long stretch without idling, then random traffic across settings.
        idle_pct = 0;
        run_random(30);
        idle_pct = 6;
        write_reg(0, 0);
        write_reg(1, 0);
        run_random(35);
        write_reg(0, 255);
        write_reg(1, 65535);
        run_random(35);
        write_reg(0, 12);
        write_reg(1, 50);
        run_random(35);
        send(FN_FLUSH, 0);
        i_in_valid <= 1'b0;

        while (sb.pending.size() != 0 && !timed_out) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        $display("Covered %0d inserts, %0d dequeues, %0d queries, %0d flushes, %0d peeks;",
                 sb.ins_cnt, sb.deq_cnt, sb.qry_cnt, sb.flush_cnt, sb.peek_cnt);
        $display("checked %0d results under four register settings.", sb.checked);
        if (sb.errors == 0 && !timed_out && sb.pending.size() == 0)
            $display("rtp_jitter_reorder_buffer verification clean");
        else
            $display("rtp_jitter_reorder_buffer verification failed");
        $finish;
    end

    initial begin
        wait (timed_out);
        $display("%0t: no transfer for %0d cycles", $time, HANG_LIMIT);
        $display("rtp_jitter_reorder_buffer verification failed");
        $finish;
    end
endmodule
